### hdl/way_partitioned_lru_replacement_defines.svh
// Assertion macros for the way-partitioned LRU replacement block
`ifndef WAY_PARTITIONED_LRU_REPLACEMENT_DEFINES_SVH
`define WAY_PARTITIONED_LRU_REPLACEMENT_DEFINES_SVH
// property checked on every rising clock edge outside reset
`define WPL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same-cycle implication from a condition to a consequence
`define WPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

### hdl/wplru_pkg.sv
// Shared types and constants for the way-partitioned LRU replacement block
package wplru_pkg;
	localparam int NUM_SETS_DEF  = 2048;
	localparam int NUM_WAYS_DEF  = 16;
	localparam int NUM_CORES_DEF = 8;
	localparam int SET_W   = 11;
	localparam int WAY_W   = 4;
	localparam int CORE_W  = 3;
	localparam int QUOTA_W = 5;
	localparam int QUOTAS_W = 40;
	localparam logic [QUOTAS_W-1:0] QUOTAS_RST = 40'd47;
	localparam logic [1:0] REG_PART   = 2'd0;
	localparam logic [1:0] REG_QUOTAS = 2'd1;
	localparam logic CMD_FIND   = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	typedef struct packed {
		logic              command;
		logic [SET_W-1:0]  set_index;
		logic [WAY_W-1:0]  way_index;
		logic [CORE_W-1:0] core_id;
		logic              is_writeback;
		logic              was_hit;
	} in_item_t;

	typedef struct packed {
		logic [WAY_W-1:0] victim_way;
		logic             no_victim;
	} out_item_t;
endpackage

### hdl/wplru_front.sv
// Front end: accepts items, screens updates, holds a two-entry queue
module wplru_front #(
	parameter int NUM_WAYS  = wplru_pkg::NUM_WAYS_DEF,
	parameter int NUM_CORES = wplru_pkg::NUM_CORES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wplru_pkg::in_item_t in_item,
	output logic                q_valid,
	input  logic                q_ready,
	output wplru_pkg::in_item_t q_item,
	output logic                q_skip
);
	`include "way_partitioned_lru_replacement_defines.svh"
	wplru_pkg::in_item_t item_q [2];
	logic skip_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push, pop, skip;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = item_q[rd_q];
	assign q_skip = skip_q[rd_q];
	assign skip = (in_item.command == wplru_pkg::CMD_UPDATE) &&
		((32'(in_item.way_index) >= NUM_WAYS) || (32'(in_item.core_id) >= NUM_CORES) ||
		(in_item.is_writeback && in_item.was_hit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_q] <= in_item;
			skip_q[wr_q] <= skip;
		end
	end

	`WPL_ASSERT(a_cnt_max, clk, arst_n, cnt_q <= 2'd2, "queue overflow")
	`WPL_ASSERT(a_full_stall, clk, arst_n, (cnt_q == 2'd2) |-> !in_ready, "full queue takes item")
	`WPL_ASSERT(a_empty, clk, arst_n, (cnt_q == 2'd0) |=> !$past(pop), "pop from empty")
endmodule

### hdl/wplru_back.sv
// Back end: clears every set row after reset, then reads a set row, picks a victim or updates ranks, writes back
module wplru_back #(
	parameter int NUM_SETS  = wplru_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS  = wplru_pkg::NUM_WAYS_DEF,
	parameter int NUM_CORES = wplru_pkg::NUM_CORES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  wplru_pkg::in_item_t  q_item,
	input  logic                 q_skip,
	input  logic                 part_en,
	input  logic [wplru_pkg::QUOTAS_W-1:0] quotas,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wplru_pkg::out_item_t out_item
);
	`include "way_partitioned_lru_replacement_defines.svh"
	localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WI_W = $clog2(NUM_WAYS);
	localparam int RK_W = $clog2(NUM_WAYS);
	localparam int CNT_W = $clog2(NUM_WAYS + 1);
	localparam int ROW_W = NUM_WAYS * (1 + wplru_pkg::CORE_W + RK_W);
	localparam int CLR_W = SET_AW;

	typedef struct packed {
		logic [NUM_WAYS-1:0] vld;
		logic [NUM_WAYS-1:0][wplru_pkg::CORE_W-1:0] own;
		logic [NUM_WAYS-1:0][RK_W-1:0] rk;
	} row_t;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} st_t;

	logic [ROW_W-1:0] mem [NUM_SETS];
	row_t row_s1, rst_row, new_row;
	st_t st_q;
	logic [CLR_W-1:0] clr_q;
	wplru_pkg::in_item_t it_s1;
	logic skip_s1;
	logic [SET_AW-1:0] set_a;
	logic [SET_AW-1:0] set_a_s1;
	logic out_full;
	logic found;
	logic [WI_W-1:0] vway;
	logic [CNT_W-1:0] taken;
	logic [wplru_pkg::QUOTA_W-1:0] quota;
	logic [WI_W-1:0] uway;
	logic [RK_W-1:0] ref_rk;
	logic is_find;

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			rst_row.vld[w] = 1'b0;
			rst_row.own[w] = '0;
			rst_row.rk[w] = RK_W'(w);
		end
	end

	assign set_a = SET_AW'(32'(q_item.set_index) % NUM_SETS);
	assign out_full = out_valid && !out_ready;
	assign q_ready = (st_q == ST_IDLE) && !out_full;
	assign is_find = (it_s1.command == wplru_pkg::CMD_FIND);
	assign quota = quotas[it_s1.core_id * wplru_pkg::QUOTA_W +: wplru_pkg::QUOTA_W];
	assign uway = WI_W'(it_s1.way_index);

	always_comb begin
		found = 1'b0;
		vway = '0;
		taken = '0;
		for (int w = 0; w < NUM_WAYS; w++)
			if (row_s1.vld[w] && row_s1.own[w] == it_s1.core_id) taken = taken + 1'b1;
		if (32'(it_s1.core_id) >= NUM_CORES) begin
			found = 1'b0;
		end else if (!part_en) begin
			for (int w = NUM_WAYS - 1; w >= 0; w--)
				if (row_s1.rk[w] == RK_W'(NUM_WAYS - 1)) begin
					found = 1'b1;
					vway = WI_W'(w);
				end
			for (int w = NUM_WAYS - 1; w >= 0; w--)
				if (!row_s1.vld[w]) begin
					found = 1'b1;
					vway = WI_W'(w);
				end
		end else if (6'(taken) < 6'(quota)) begin
			for (int w = NUM_WAYS - 1; w >= 0; w--)
				if (!row_s1.vld[w]) begin
					found = 1'b1;
					vway = WI_W'(w);
				end
		end else if (quota != '0) begin
			for (int w = NUM_WAYS - 1; w >= 0; w--)
				if (row_s1.own[w] == it_s1.core_id &&
						6'(row_s1.rk[w]) == 6'(quota) - 6'd1) begin
					found = 1'b1;
					vway = WI_W'(w);
				end
		end
	end

	always_comb begin
		new_row = row_s1;
		if (!it_s1.was_hit) begin
			new_row.vld[uway] = 1'b1;
			new_row.own[uway] = it_s1.core_id;
		end
		ref_rk = row_s1.rk[uway];
		for (int w = 0; w < NUM_WAYS; w++)
			if ((!part_en || new_row.own[w] == it_s1.core_id) && row_s1.rk[w] < ref_rk)
				new_row.rk[w] = row_s1.rk[w] + 1'b1;
		new_row.rk[uway] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
			out_item <= '0;
		end else begin
			if (out_valid && out_ready && !(st_q == ST_EXEC && is_find))
				out_valid <= 1'b0;
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(NUM_SETS - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_valid && q_ready) st_q <= ST_EXEC;
				end
				ST_EXEC: begin
					st_q <= ST_IDLE;
					if (is_find) begin
						out_valid <= 1'b1;
						out_item.victim_way <= found ? wplru_pkg::WAY_W'(vway) : '0;
						out_item.no_victim <= !found;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_CLEAR) mem[clr_q] <= rst_row;
		else if (st_q == ST_EXEC && !is_find && !skip_s1) mem[set_a_s1] <= new_row;
		if (q_valid && q_ready) begin
			row_s1 <= mem[set_a];
			it_s1 <= q_item;
			skip_s1 <= q_skip;
			set_a_s1 <= set_a;
		end
	end

	`WPL_ASSERT_IMP(a_no_take_clear, clk, arst_n, st_q == ST_CLEAR, !q_ready, "item during clear")
	`WPL_ASSERT(a_exec_after, clk, arst_n, (st_q == ST_EXEC) |-> $past(q_valid && q_ready), "exec without item")
	`WPL_ASSERT_IMP(a_novic_zero, clk, arst_n, out_valid && out_item.no_victim, out_item.victim_way == '0, "victim not zero")
endmodule

### hdl/way_partitioned_lru_replacement.sv
// Top level of the way-partitioned LRU replacement block
// Usage:
//  - in channel (in_valid/in_ready/in_item): find-victim or update commands.
//  - out channel (out_valid/out_ready/out_item): one item per find-victim.
//  - APB port: register 0 partition_enable at 0x0, register 1 way_quotas at 0x8.
// Front queue holds two items; the back end reads a set row from a one-port
// memory, then picks or updates and writes the row back.
// A find result passes the front queue, the set row register and the result
// register. The back end takes no new item while it executes one, as each
// item reads and may then write back through the single set memory port.
// After reset the back end sweeps all NUM_SETS rows writing reset rows; the
// queue fills meanwhile and then holds. A stalled receiver holds the result
// register and stops the back end; the queue keeps taking items until full.
module way_partitioned_lru_replacement #(
	parameter int NUM_SETS  = wplru_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS  = wplru_pkg::NUM_WAYS_DEF,
	parameter int NUM_CORES = wplru_pkg::NUM_CORES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wplru_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wplru_pkg::out_item_t out_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready
);
	logic part_en_q;
	logic [wplru_pkg::QUOTAS_W-1:0] quotas_q;
	logic q_valid, q_ready, q_skip;
	wplru_pkg::in_item_t q_item;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = {1'b0, paddr[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_en_q <= 1'b1;
			quotas_q <= wplru_pkg::QUOTAS_RST;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			unique case (reg_idx)
				wplru_pkg::REG_PART: part_en_q <= pwdata[0];
				wplru_pkg::REG_QUOTAS: quotas_q <= pwdata[wplru_pkg::QUOTAS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			wplru_pkg::REG_PART: prdata = {63'd0, part_en_q};
			wplru_pkg::REG_QUOTAS: prdata = {24'd0, quotas_q};
			default: prdata = '0;
		endcase
	end

	wplru_front #(.NUM_WAYS(NUM_WAYS), .NUM_CORES(NUM_CORES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.q_skip(q_skip)
	);

	wplru_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .NUM_CORES(NUM_CORES)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_item(q_item), .q_skip(q_skip), .part_en(part_en_q), .quotas(quotas_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule

### sim/way_partitioned_lru_replacement_tb.sv
// Testbench for the way-partitioned LRU replacement block
module way_partitioned_lru_replacement_tb;
	localparam int N_SETS  = 2048;
	localparam int N_WAYS  = 16;
	localparam int N_CORES = 8;
	localparam int HOT_SETS = 4;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	wplru_pkg::in_item_t  in_item;
	logic                 out_valid;
	logic                 out_ready;
	wplru_pkg::out_item_t out_item;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [3:0]           paddr;
	logic [63:0]          pwdata;
	logic [63:0]          prdata;
	logic                 pready;

	way_partitioned_lru_replacement dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the replacement state
	logic                                part_en;
	logic [wplru_pkg::QUOTAS_W-1:0]      quotas;
	logic [N_WAYS-1:0]                   valid_bits [N_SETS];
	logic [wplru_pkg::CORE_W-1:0]        owner_of   [N_SETS][N_WAYS];
	logic [wplru_pkg::WAY_W-1:0]         rank_of    [N_SETS][N_WAYS];

	wplru_pkg::out_item_t victims_due [$];
	int        errors;

	typedef struct {
		wplru_pkg::in_item_t  item;
		bit                   has_fixed;
		wplru_pkg::out_item_t fixed;
	} stim_row_t;
	stim_row_t rows [$];

	function automatic wplru_pkg::in_item_t mk(logic cmd, int set, int way, int core,
			logic wb, logic hit);
		wplru_pkg::in_item_t it;
		it.command = cmd;
		it.set_index = set[wplru_pkg::SET_W-1:0];
		it.way_index = way[wplru_pkg::WAY_W-1:0];
		it.core_id = core[wplru_pkg::CORE_W-1:0];
		it.is_writeback = wb;
		it.was_hit = hit;
		return it;
	endfunction

	function automatic wplru_pkg::out_item_t choose_victim(wplru_pkg::in_item_t it);
		wplru_pkg::out_item_t r;
		int s, c, taken, q;
		s = it.set_index;
		c = it.core_id;
		r.victim_way = '0;
		r.no_victim = 1'b1;
		if (!part_en) begin
			for (int w = 0; w < N_WAYS; w++)
				if (r.no_victim && !valid_bits[s][w]) begin
					r.victim_way = w[wplru_pkg::WAY_W-1:0];
					r.no_victim = 1'b0;
				end
			for (int w = 0; w < N_WAYS; w++)
				if (r.no_victim && rank_of[s][w] == N_WAYS - 1) begin
					r.victim_way = w[wplru_pkg::WAY_W-1:0];
					r.no_victim = 1'b0;
				end
			return r;
		end
		q = int'((quotas >> (wplru_pkg::QUOTA_W * c)) & 40'h1f);
		taken = 0;
		for (int w = 0; w < N_WAYS; w++)
			if (valid_bits[s][w] && owner_of[s][w] == c)
				taken++;
		if (taken < q) begin
			for (int w = 0; w < N_WAYS; w++)
				if (r.no_victim && !valid_bits[s][w]) begin
					r.victim_way = w[wplru_pkg::WAY_W-1:0];
					r.no_victim = 1'b0;
				end
		end else if (q != 0) begin
			for (int w = 0; w < N_WAYS; w++)
				if (r.no_victim && owner_of[s][w] == c && rank_of[s][w] == q - 1) begin
					r.victim_way = w[wplru_pkg::WAY_W-1:0];
					r.no_victim = 1'b0;
				end
		end
		return r;
	endfunction

	task automatic record_access(wplru_pkg::in_item_t it);
		int s, w, c;
		logic [wplru_pkg::WAY_W-1:0] ref_rank;
		s = it.set_index;
		w = it.way_index;
		c = it.core_id;
		if (it.is_writeback && it.was_hit)
			return;
		if (!it.was_hit) begin
			valid_bits[s][w] = 1'b1;
			owner_of[s][w] = c[wplru_pkg::CORE_W-1:0];
		end
		ref_rank = rank_of[s][w];
		for (int i = 0; i < N_WAYS; i++)
			if (!(part_en && owner_of[s][i] != c) && rank_of[s][i] < ref_rank)
				rank_of[s][i]++;
		rank_of[s][w] = '0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver with its own stall pattern
	initial begin
		int phase;
		out_ready = 1'b0;
		phase = 0;
		forever begin
			@(posedge clk);
			phase++;
			if ((phase / 400) % 3 == 2)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
		end
	end

	always @(posedge clk) begin
		wplru_pkg::out_item_t exp_v;
		if (arst_n && out_valid && out_ready) begin
			if (victims_due.size() == 0) begin
				$display("%0t unexpected result %p", $time, out_item);
				errors++;
			end else begin
				exp_v = victims_due.pop_front();
				if (out_item.victim_way !== exp_v.victim_way) begin
					$display("%0t victim_way expected %0d actual %0d",
						$time, exp_v.victim_way, out_item.victim_way);
					errors++;
				end
				if (out_item.no_victim !== exp_v.no_victim) begin
					$display("%0t no_victim expected %0d actual %0d",
						$time, exp_v.no_victim, out_item.no_victim);
					errors++;
				end
			end
		end
	end

	task automatic send(wplru_pkg::in_item_t it, bit has_fixed, wplru_pkg::out_item_t fixed);
		wplru_pkg::out_item_t pred;
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		if (it.command == wplru_pkg::CMD_FIND) begin
			pred = choose_victim(it);
			if (has_fixed && pred !== fixed) begin
				$display("%0t table row expected %p predictor %p", $time, fixed, pred);
				errors++;
			end
			victims_due.push_back(pred);
		end else begin
			record_access(it);
		end
	endtask

	task automatic idle_gap();
		int n;
		if ($urandom_range(0, 4) != 0)
			return;
		n = $urandom_range(1, 6);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00} << 1;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == wplru_pkg::REG_PART)
			part_en = val[0];
		else
			quotas = val[wplru_pkg::QUOTAS_W-1:0];
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (victims_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		wplru_pkg::in_item_t it;
		int burst;
		wplru_pkg::out_item_t none;
		none = '0;
		burst = 0;
		for (int k = 0; k < count; k++) begin
			it.command = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 9) == 0)
				it.set_index = wplru_pkg::SET_W'($urandom_range(0, N_SETS - 1));
			else
				it.set_index = wplru_pkg::SET_W'($urandom_range(0, HOT_SETS - 1) * 513);
			it.way_index = wplru_pkg::WAY_W'($urandom_range(0, N_WAYS - 1));
			it.core_id = wplru_pkg::CORE_W'(($urandom_range(0, 3) == 0) ?
				$urandom_range(0, N_CORES - 1) : $urandom_range(0, 2));
			it.is_writeback = $urandom_range(0, 4) == 0;
			it.was_hit = $urandom_range(0, 1) != 0;
			send(it, 1'b0, none);
			if (burst == 0) begin
				idle_gap();
				burst = $urandom_range(0, 20);
			end else begin
				burst--;
			end
		end
	endtask

	initial begin
		errors = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		part_en = 1'b1;
		quotas = wplru_pkg::QUOTAS_RST;
		for (int s = 0; s < N_SETS; s++) begin
			valid_bits[s] = '0;
			for (int w = 0; w < N_WAYS; w++) begin
				owner_of[s][w] = '0;
				rank_of[s][w] = w[wplru_pkg::WAY_W-1:0];
			end
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; fixed results only where obvious
		rows.push_back('{mk(wplru_pkg::CMD_FIND, 0, 0, 0, 0, 0), 1, '{4'd0, 1'b0}});
		rows.push_back('{mk(wplru_pkg::CMD_FIND, 2047, 0, 7, 0, 0), 1, '{4'd0, 1'b1}});
		rows.push_back('{mk(wplru_pkg::CMD_FIND, 5, 0, 2, 0, 0), 1, '{4'd0, 1'b1}});
		rows.push_back('{mk(wplru_pkg::CMD_UPDATE, 0, 0, 1, 0, 0), 0, '0});
		rows.push_back('{mk(wplru_pkg::CMD_FIND, 0, 0, 1, 0, 0), 1, '{4'd0, 1'b0}});
		rows.push_back('{mk(wplru_pkg::CMD_UPDATE, 0, 15, 0, 0, 0), 0, '0});
		rows.push_back('{mk(wplru_pkg::CMD_UPDATE, 0, 15, 0, 1, 1), 0, '0});
		rows.push_back('{mk(wplru_pkg::CMD_UPDATE, 0, 15, 0, 0, 1), 0, '0});
		rows.push_back('{mk(wplru_pkg::CMD_UPDATE, 0, 3, 0, 1, 0), 0, '0});
		rows.push_back('{mk(wplru_pkg::CMD_FIND, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk(wplru_pkg::CMD_UPDATE, 2047, 15, 7, 1, 0), 0, '0});
		rows.push_back('{mk(wplru_pkg::CMD_FIND, 2047, 15, 7, 1, 1), 0, '0});
		rows.push_back('{mk(wplru_pkg::CMD_UPDATE, 2047, 8, 1, 0, 0), 0, '0});
		rows.push_back('{mk(wplru_pkg::CMD_FIND, 2047, 0, 1, 0, 0), 0, '0});
		foreach (rows[i])
			send(rows[i].item, rows[i].has_fixed, rows[i].fixed);
		drain();

		apb_write(wplru_pkg::REG_PART, 64'd0);
		apb_write(wplru_pkg::REG_QUOTAS, 64'hff_ffff_ffff);
		random_phase(300);
		drain();
		apb_write(wplru_pkg::REG_PART, 64'd1);
		random_phase(450);
		drain();
		apb_write(wplru_pkg::REG_QUOTAS, 64'd0);
		random_phase(200);
		drain();
		// small quotas so cores reach them often
		apb_write(wplru_pkg::REG_QUOTAS,
			{24'd0, 5'd2, 5'd1, 5'd3, 5'd4, 5'd16, 5'd3, 5'd2, 5'd5});
		random_phase(450);
		drain();
		apb_write(wplru_pkg::REG_QUOTAS, {$urandom(), $urandom()});
		random_phase(250);
		drain();
		apb_write(wplru_pkg::REG_PART, 64'd0);
		random_phase(150);
		drain();

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

### way_partitioned_lru_replacement.f
+incdir+hdl
hdl/wplru_pkg.sv
hdl/wplru_front.sv
hdl/wplru_back.sv
hdl/way_partitioned_lru_replacement.sv
sim/way_partitioned_lru_replacement_tb.sv
